/* rtl/skvl_pkg.sv */
`default_nettype none

package skvl_pkg;

  localparam int KEY_BYTES = 32;
  localparam int KEY_IDX_W = $clog2(KEY_BYTES);

  localparam logic [31:0] KEY_WORDS [8] = '{
    32'hfaf4e9d3, 32'ha74e9c39, 32'h73e7ce9d, 32'h3b76edda,
    32'hb56bd7ae, 32'h5dbb76ed, 32'hdbb76fdf, 32'hbf7ffefd
  };

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_EQ  = 8'h3d;

  localparam logic [1:0] CFG_KEY_NAME    = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LONG  = 2'd2
  } st_code_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_byte;
    logic load_status;
  } dp_cmd_t;

  typedef struct packed {
    logic evt;
    logic replay;
  } dp_stat_t;

  function automatic logic [7:0] key_byte(input logic [KEY_IDX_W-1:0] p);
    logic [31:0] word;
    word = KEY_WORDS[p[KEY_IDX_W-1:2]];
    return word[8*(3-p[1:0]) +: 8];
  endfunction

endpackage

`default_nettype wire

/* rtl/skvl_in_if.sv */
`default_nettype none

interface skvl_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] cipher_byte;

  modport source (output valid, start_req, cipher_byte, input ready);
  modport sink (input valid, start_req, cipher_byte, output ready);
endinterface

`default_nettype wire

/* rtl/skvl_out_if.sv */
`default_nettype none

interface skvl_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] value_byte;
  logic [1:0] status_code;
  logic [5:0] value_length;
  logic       last;

  modport source (
    output valid, is_status, value_byte, status_code, value_length, last,
    input ready
  );
  modport sink (
    input valid, is_status, value_byte, status_code, value_length, last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/skvl_cfg_if.sv */
`default_nettype none

interface skvl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/skvl_dp.sv */
`default_nettype none

module skvl_dp #(
  parameter int FILE_BYTES      = 256,
  parameter int NAME_MAX_CHARS  = 8,
  parameter int VALUE_MAX_BYTES = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  skvl_pkg::dp_cmd_t                      cmd,
  output skvl_pkg::dp_stat_t                     stat,
  input  logic [$clog2(VALUE_MAX_BYTES)-1:0]     rd_addr,
  output logic [$clog2(VALUE_MAX_BYTES+1)-1:0]   value_len,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [63:0]                            cfg_data,
  input  logic                                   start_req,
  input  logic [7:0]                             cipher_byte,
  output logic                                   is_status,
  output logic [7:0]                             value_byte,
  output logic [1:0]                             status_code,
  output logic [5:0]                             value_length,
  output logic                                   last
);
  import skvl_pkg::*;

  localparam int PW = $clog2(FILE_BYTES);
  localparam int AW = $clog2(VALUE_MAX_BYTES);
  localparam int CW = $clog2(VALUE_MAX_BYTES+1);
  localparam logic [PW-1:0] LAST_POS = PW'(FILE_BYTES-1);
  localparam logic [3:0] NAME_MAX = 4'(NAME_MAX_CHARS);
  localparam logic [6:0] VMAX7 = 7'(VALUE_MAX_BYTES);
  localparam logic [CW-1:0] VMAXC = CW'(VALUE_MAX_BYTES);

  typedef enum logic [3:0] {
    PH_NAME  = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_REST  = 4'b0100,
    PH_SEP   = 4'b1000
  } phase_t;

  logic [63:0]   key_name;
  logic [3:0]    key_length;
  logic [6:0]    value_limit;

  logic [PW-1:0] pos, pos_c, pos_next;
  phase_t        phase, phase_c, phase_w, phase_next;
  logic          done, done_c, done_next;
  logic [3:0]    name_cnt, cnt_c, cnt_w, cnt_next;
  logic          match, match_c, match_w, match_next;
  logic [CW-1:0] vcnt, vcnt_c, vcnt_next;

  logic [7:0]    b;
  logic          term;
  logic [3:0]    eff_len;
  logic [7:0]    want;
  logic [6:0]    lim;
  logic          nf;
  logic          close;
  logic          wr_en;
  st_code_t      code;

  logic [7:0]    mem [VALUE_MAX_BYTES];
  logic [7:0]    rd_data;
  st_code_t      stat_code;
  logic [CW-1:0] stat_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_name    <= '0;
      key_length  <= '0;
      value_limit <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_NAME:    key_name <= cfg_data;
        CFG_KEY_LENGTH:  key_length <= cfg_data[3:0];
        CFG_VALUE_LIMIT: value_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (key_length > NAME_MAX) ? NAME_MAX : key_length;
  assign lim     = (value_limit > VMAX7) ? VMAX7 : value_limit;

  always_comb begin
    pos_c   = start_req ? '0 : pos;
    phase_c = start_req ? PH_NAME : phase;
    done_c  = start_req ? 1'b0 : done;
    cnt_c   = start_req ? '0 : name_cnt;
    match_c = start_req ? 1'b1 : match;
    vcnt_c  = start_req ? '0 : vcnt;

    pos_next   = pos_c;
    phase_next = phase_c;
    done_next  = done_c;
    cnt_next   = cnt_c;
    match_next = match_c;
    vcnt_next  = vcnt_c;
    phase_w    = phase_c;
    cnt_w      = cnt_c;
    match_w    = match_c;
    wr_en      = 1'b0;
    nf         = 1'b0;
    close      = 1'b0;

    b    = cipher_byte ^ key_byte(pos_c[KEY_IDX_W-1:0]);
    term = (b == CHAR_CR) || (b == CHAR_LF);
    want = 8'h00;

    if (!done_c) begin
      if (phase_c == PH_SEP && b != CHAR_NUL && !term) begin
        phase_w = PH_NAME;
        cnt_w   = '0;
        match_w = 1'b1;
      end
      phase_next = phase_w;
      cnt_next   = cnt_w;
      match_next = match_w;
      want       = key_name[8*(7-cnt_w[2:0]) +: 8];

      unique case (phase_w)
        PH_SEP: begin
          if (b == CHAR_NUL) nf = 1'b1;
        end
        PH_NAME: begin
          if (b == CHAR_NUL || term) begin
            nf = 1'b1;
          end else if (b == CHAR_EQ) begin
            if (match_w && cnt_w == eff_len) begin
              phase_next = PH_VALUE;
              vcnt_next  = '0;
            end else begin
              phase_next = PH_REST;
            end
          end else begin
            if (!(cnt_w < eff_len && want == b)) match_next = 1'b0;
            if (cnt_w != 4'hf) cnt_next = cnt_w + 4'd1;
          end
        end
        PH_VALUE: begin
          if (b == CHAR_NUL || term) begin
            close = 1'b1;
          end else if (vcnt_c < VMAXC) begin
            wr_en     = 1'b1;
            vcnt_next = vcnt_c + CW'(1);
          end
        end
        PH_REST: begin
          if (b == CHAR_NUL) nf = 1'b1;
          else if (term) phase_next = PH_SEP;
        end
        default: ;
      endcase

      if (!nf && !close) begin
        if (pos_c == LAST_POS) begin
          if (phase_next == PH_VALUE) close = 1'b1;
          else nf = 1'b1;
        end else begin
          pos_next = pos_c + PW'(1);
        end
      end
      if (nf || close) done_next = 1'b1;
    end

    if (nf || lim == 7'd0) code = ST_NOT_FOUND;
    else if (7'(vcnt_next) >= lim) code = ST_TOO_LONG;
    else code = ST_FOUND;
  end

  assign stat.evt    = nf || close;
  assign stat.replay = (code == ST_FOUND) && (vcnt_next != '0);
  assign value_len   = stat_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      phase    <= PH_NAME;
      done     <= 1'b0;
      name_cnt <= '0;
      match    <= 1'b1;
      vcnt     <= '0;
    end else if (cmd.accept) begin
      pos      <= pos_next;
      phase    <= phase_next;
      done     <= done_next;
      name_cnt <= cnt_next;
      match    <= match_next;
      vcnt     <= vcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) mem[vcnt_c[AW-1:0]] <= b;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.evt) begin
      stat_code <= code;
      stat_len  <= (code == ST_FOUND) ? vcnt_next : '0;
    end
    if (cmd.load_byte) begin
      is_status    <= 1'b0;
      value_byte   <= rd_data;
      status_code  <= ST_FOUND;
      value_length <= '0;
      last         <= 1'b0;
    end else if (cmd.load_status) begin
      is_status    <= 1'b1;
      value_byte   <= '0;
      status_code  <= stat_code;
      value_length <= 6'(stat_len);
      last         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/skvl_ctrl.sv */
`default_nettype none

module skvl_ctrl #(
  parameter int VALUE_MAX_BYTES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output skvl_pkg::dp_cmd_t                     cmd,
  input  skvl_pkg::dp_stat_t                    stat,
  input  logic [$clog2(VALUE_MAX_BYTES+1)-1:0]  value_len,
  output logic [$clog2(VALUE_MAX_BYTES)-1:0]    rd_addr
);
  import skvl_pkg::*;

  localparam int AW = $clog2(VALUE_MAX_BYTES);
  localparam int CW = $clog2(VALUE_MAX_BYTES+1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SEND   = 4'b0100,
    S_STATUS = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic          out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign rd_addr  = idx[AW-1:0];

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    cmd.accept      = in_valid && in_ready;
    cmd.rd_en       = 1'b0;
    cmd.load_byte   = 1'b0;
    cmd.load_status = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && stat.evt) begin
          idx_next   = '0;
          state_next = stat.replay ? S_READ : S_STATUS;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          cmd.load_byte = 1'b1;
          if (CW'(idx + CW'(1)) == value_len) begin
            state_next = S_STATUS;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_READ;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.load_byte || cmd.load_status) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/scrambled_key_value_lookup_top.sv */
// Throughput: one file byte per cycle while no result is due.
// A deciding byte's status is registered and loaded into the output register from
// S_STATUS once the output is free, after a found value replays each byte through
// S_READ and S_SEND (the value memory read is registered); input is held off until
// the status is loaded. Reset: synchronous active-high rst restores the parser,
// position, config and FSM to defaults; value memory and output data are not cleared.
`default_nettype none

module scrambled_key_value_lookup_top #(
  parameter int FILE_BYTES      = 256,
  parameter int NAME_MAX_CHARS  = 8,
  parameter int VALUE_MAX_BYTES = 64
) (
  input  logic   clk,
  input  logic   rst,
  skvl_in_if.sink     items,
  skvl_out_if.source  results,
  skvl_cfg_if.sink    cfg
);
  import skvl_pkg::*;

  localparam int AW = $clog2(VALUE_MAX_BYTES);
  localparam int CW = $clog2(VALUE_MAX_BYTES+1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] value_len;

  assign cfg.ready = 1'b1;

  skvl_ctrl #(
    .VALUE_MAX_BYTES(VALUE_MAX_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .cmd       (cmd),
    .stat      (stat),
    .value_len (value_len),
    .rd_addr   (rd_addr)
  );

  skvl_dp #(
    .FILE_BYTES     (FILE_BYTES),
    .NAME_MAX_CHARS (NAME_MAX_CHARS),
    .VALUE_MAX_BYTES(VALUE_MAX_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .rd_addr      (rd_addr),
    .value_len    (value_len),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .start_req    (items.start_req),
    .cipher_byte  (items.cipher_byte),
    .is_status    (results.is_status),
    .value_byte   (results.value_byte),
    .status_code  (results.status_code),
    .value_length (results.value_length),
    .last         (results.last)
  );

endmodule

`default_nettype wire

/* verif/scrambled_key_value_lookup_top_tb.sv */
module scrambled_key_value_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skvl_pkg::*;

  localparam int FILE_BYTES  = 256;
  localparam int NAME_MAX    = 8;
  localparam int VALUE_MAX   = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [63:0] HOST = {"host", 32'd0};
  localparam logic [63:0] ALPHA = "ABCDEFGH";

  typedef enum logic [1:0] {SCAN_NAME, SCAN_VALUE, SKIP_LINE, SKIP_BREAK} scan_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] value_byte;
    st_code_t   status_code;
    logic [5:0] value_length;
    logic       last;
  } lookup_out_t;

  typedef struct {
    bit          wr;
    logic [63:0] name;
    logic [3:0]  nlen;
    logic [6:0]  lim;
    bit          start;
    string       text;
    int          fill;
    string       tail;
    bit          pad;
    bit          chk;
    st_code_t    code;
    logic [5:0]  len;
  } dir_row_t;

  // A caret in the text stands for a NUL byte.
  dir_row_t dir_rows[25] = '{
    '{0, 64'd0, 4'd0, 7'd64,  0, "=v1\n", 0, "", 0, 1, ST_FOUND, 6'd2},
    '{1, HOST,  4'd4, 7'd64,  1, "host=abc\n", 0, "", 0, 1, ST_FOUND, 6'd3},
    '{1, HOST,  4'd4, 7'd64,  1, "Host=abc\n^", 0, "", 0, 1, ST_NOT_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd64,  1, "a=1\015\n\015\nhost=xyz\015", 0, "", 0, 1, ST_FOUND, 6'd3},
    '{1, HOST,  4'd4, 7'd64,  1, "hostxyz\n", 0, "", 0, 1, ST_NOT_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd64,  1, "\015host=1\n", 0, "", 0, 1, ST_NOT_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd64,  1, "ho^", 0, "", 0, 1, ST_NOT_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd64,  1, "hosts=1\nhos=2\nhost=3\n", 0, "", 0, 1, ST_FOUND, 6'd1},
    '{1, HOST,  4'd4, 7'd64,  1, "host=\n", 0, "", 0, 1, ST_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd4,   1, "host=abcd\n", 0, "", 0, 1, ST_TOO_LONG, 6'd0},
    '{1, HOST,  4'd4, 7'd4,   1, "host=abc\n", 0, "", 0, 1, ST_FOUND, 6'd3},
    '{1, HOST,  4'd4, 7'd1,   1, "host=\n", 0, "", 0, 1, ST_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd0,   1, "host=\n", 0, "", 0, 1, ST_NOT_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd127, 1, "host=", 63, "\n", 0, 1, ST_FOUND, 6'd63},
    '{1, HOST,  4'd4, 7'd127, 1, "host=", 64, "\n", 0, 1, ST_TOO_LONG, 6'd0},
    '{1, HOST,  4'd4, 7'd64,  1, "host=", 70, "\015", 0, 1, ST_TOO_LONG, 6'd0},
    '{1, ALPHA, 4'd8, 7'd64,  1, "ABCDEFGH=Zz\n", 0, "", 0, 1, ST_FOUND, 6'd2},
    '{1, ALPHA, 4'd15, 7'd64, 1, "ABCDEFGH=q\n", 0, "", 0, 1, ST_FOUND, 6'd1},
    '{1, {"ab", 48'd0}, 4'd3, 7'd64, 1, "ab=1\n^", 0, "", 0, 1, ST_NOT_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd64,  1, "host=", 10, "", 1, 1, ST_FOUND, 6'd10},
    '{1, HOST,  4'd4, 7'd64,  1, "x=1", 0, "", 1, 1, ST_NOT_FOUND, 6'd0},
    '{1, HOST,  4'd4, 7'd64,  1, "host=ab", 0, "", 0, 0, ST_FOUND, 6'd0},
    '{0, HOST,  4'd4, 7'd64,  1, "host=cd\n", 0, "", 0, 1, ST_FOUND, 6'd2},
    '{1, HOST,  4'd4, 7'd64,  1, "host=ab^host=2\n", 0, "", 0, 1, ST_FOUND, 6'd2},
    '{1, HOST,  4'd4, 7'd64,  1, "host==x=\n", 0, "", 0, 1, ST_FOUND, 6'd3}
  };

  logic clk = 1'b0;
  logic rst;

  skvl_in_if  in_ch ();
  skvl_out_if out_ch ();
  skvl_cfg_if cfg_ch ();

  scrambled_key_value_lookup_top #(
    .FILE_BYTES(FILE_BYTES),
    .NAME_MAX_CHARS(NAME_MAX),
    .VALUE_MAX_BYTES(VALUE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(in_ch),
    .results(out_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] want_name  = '0;
  logic [3:0]  want_len   = '0;
  logic [6:0]  want_limit = 7'd64;

  int         file_pos;
  scan_t      scan_state;
  bit         search_over;
  int         name_cnt;
  bit         name_ok;
  int         val_cnt;
  logic [7:0] val_mem [VALUE_MAX];

  lookup_out_t lookup_results_due[$];
  logic [7:0]  file_text[$];

  int         mismatches    = 0;
  int         items_sent    = 0;
  int         statuses_seen = 0;
  logic [1:0] last_code;
  logic [5:0] last_len;
  bit         quiet   = 1'b0;
  bit         hold_rx = 1'b0;

  function automatic logic [7:0] key_at(int pos);
    logic [31:0] w;
    w = KEY_WORDS[(pos % KEY_BYTES) / 4];
    return w[31 - 8 * (pos % 4) -: 8];
  endfunction

  function automatic int name_len_eff();
    return (want_len > NAME_MAX) ? NAME_MAX : int'(want_len);
  endfunction

  function automatic void restart_search();
    file_pos    = 0;
    scan_state  = SCAN_NAME;
    search_over = 1'b0;
    name_cnt    = 0;
    name_ok     = 1'b1;
    val_cnt     = 0;
  endfunction

  function automatic void push_status(st_code_t code, logic [5:0] len);
    lookup_results_due.push_back(lookup_out_t'{1'b1, 8'h00, code, len, 1'b1});
    search_over = 1'b1;
  endfunction

  function automatic void finish_value();
    int lim;
    lim = (want_limit > VALUE_MAX) ? VALUE_MAX : int'(want_limit);
    if (lim == 0) begin
      push_status(ST_NOT_FOUND, 6'd0);
    end else if (val_cnt >= lim) begin
      push_status(ST_TOO_LONG, 6'd0);
    end else begin
      for (int i = 0; i < val_cnt; i++)
        lookup_results_due.push_back(lookup_out_t'{1'b0, val_mem[i], ST_FOUND, 6'd0, 1'b0});
      push_status(ST_FOUND, 6'(val_cnt));
    end
  endfunction

  function automatic void lookup_byte(logic st, logic [7:0] cb);
    logic [7:0] b;
    logic       brk;
    if (st) restart_search();
    if (search_over) return;
    b = cb ^ key_at(file_pos);
    brk = (b == CHAR_CR) || (b == CHAR_LF);
    if (scan_state == SKIP_BREAK) begin
      if (b == CHAR_NUL) begin
        push_status(ST_NOT_FOUND, 6'd0);
        return;
      end
      if (!brk) begin
        name_cnt   = 0;
        name_ok    = 1'b1;
        scan_state = SCAN_NAME;
      end
    end
    case (scan_state)
      SCAN_NAME: begin
        if (b == CHAR_NUL || brk) begin
          push_status(ST_NOT_FOUND, 6'd0);
          return;
        end
        if (b == CHAR_EQ) begin
          if (name_ok && name_cnt == name_len_eff()) begin
            scan_state = SCAN_VALUE;
            val_cnt    = 0;
          end else begin
            scan_state = SKIP_LINE;
          end
        end else begin
          if (name_cnt >= name_len_eff() || want_name[63 - 8 * name_cnt -: 8] != b)
            name_ok = 1'b0;
          if (name_cnt < 15) name_cnt++;
        end
      end
      SCAN_VALUE: begin
        if (b == CHAR_NUL || brk) begin
          finish_value();
          return;
        end
        if (val_cnt < VALUE_MAX) begin
          val_mem[val_cnt] = b;
          val_cnt++;
        end
      end
      SKIP_LINE: begin
        if (b == CHAR_NUL) begin
          push_status(ST_NOT_FOUND, 6'd0);
          return;
        end
        if (brk) scan_state = SKIP_BREAK;
      end
      default: ;
    endcase
    if (file_pos + 1 >= FILE_BYTES) begin
      if (scan_state == SCAN_VALUE) finish_value();
      else push_status(ST_NOT_FOUND, 6'd0);
      return;
    end
    file_pos++;
  endfunction

  function automatic void report_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  function automatic void check_result();
    lookup_out_t want;
    if (lookup_results_due.size() == 0) begin
      mismatches++;
      $display("%0t: expected no result, got status %0b byte %0h code %0d length %0d",
               $time, out_ch.is_status, out_ch.value_byte, out_ch.status_code,
               out_ch.value_length);
      return;
    end
    want = lookup_results_due.pop_front();
    report_field("is_status", want.is_status, out_ch.is_status);
    report_field("value_byte", want.value_byte, out_ch.value_byte);
    report_field("status_code", want.status_code, out_ch.status_code);
    report_field("value_length", want.value_length, out_ch.value_length);
    report_field("last", want.last, out_ch.last);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        if (out_ch.is_status) begin
          statuses_seen++;
          last_code = out_ch.status_code;
          last_len  = out_ch.value_length;
        end
      end
      if (in_ch.valid && in_ch.ready) lookup_byte(in_ch.start_req, in_ch.cipher_byte);
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("scrambled_key_value_lookup_top_tb: errors");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_KEY_NAME:    want_name  = val;
      CFG_KEY_LENGTH:  want_len   = val[3:0];
      CFG_VALUE_LIMIT: want_limit = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] nm, input logic [3:0] ln,
                            input logic [6:0] lm);
    write_reg(CFG_KEY_NAME, nm);
    write_reg(CFG_KEY_LENGTH, {60'd0, ln});
    write_reg(CFG_VALUE_LIMIT, {57'd0, lm});
  endtask

  task automatic send_item(input logic st, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_req   <= st;
    in_ch.cipher_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_file(input bit st);
    foreach (file_text[i]) send_item(st && i == 0, file_text[i] ^ key_at(i));
  endtask

  task automatic drain();
    stop_sending();
    while (lookup_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A plain NUL decides the search in every parser state.
  task automatic close_search();
    stop_sending();
    while (!search_over) begin
      send_item(1'b0, key_at(file_pos));
      stop_sending();
    end
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++)
      file_text.push_back((s[i] == "^") ? CHAR_NUL : s[i]);
  endfunction

  function automatic logic [7:0] text_char(bit allow_eq);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CHAR_NUL || c == CHAR_CR || c == CHAR_LF || (!allow_eq && c == CHAR_EQ));
    return c;
  endfunction

  task automatic load_row(input dir_row_t row);
    int pad_len;
    file_text.delete();
    push_text(row.text);
    repeat (row.fill) file_text.push_back("k");
    push_text(row.tail);
    if (row.pad) begin
      pad_len = FILE_BYTES - file_text.size() - 3;
      file_text.push_front(CHAR_LF);
      repeat (pad_len) file_text.push_front("y");
      file_text.push_front(CHAR_EQ);
      file_text.push_front("z");
    end
  endtask

  task automatic add_skip_line();
    int m;
    m = $urandom_range(0, name_len_eff());
    for (int i = 0; i < m; i++) file_text.push_back(want_name[63 - 8 * i -: 8]);
    repeat ($urandom_range(0, 2)) file_text.push_back(text_char(1'b0));
    file_text.push_back(CHAR_EQ);
    repeat ($urandom_range(0, 6)) file_text.push_back(text_char(1'b1));
    repeat ($urandom_range(1, 3)) file_text.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic make_random_file();
    int kind;
    int vlen;
    int lim;
    file_text.delete();
    kind = $urandom_range(99);
    lim = (want_limit > VALUE_MAX) ? VALUE_MAX : int'(want_limit);
    if (kind < 8) begin
      repeat ($urandom_range(1, 40)) file_text.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(0, 3)) add_skip_line();
    if (kind >= 80 && kind < 90) begin
      file_text.push_back(CHAR_NUL);
      return;
    end
    for (int i = 0; i < name_len_eff(); i++) file_text.push_back(want_name[63 - 8 * i -: 8]);
    if (kind < 80) begin
      file_text.push_back(CHAR_EQ);
      case ($urandom_range(2))
        0: vlen = $urandom_range(0, 12);
        1: vlen = $urandom_range((lim > 0) ? lim - 1 : 0, lim + 1);
        default: vlen = $urandom_range(0, 70);
      endcase
      repeat (vlen) file_text.push_back(text_char(1'b1));
    end
    case ($urandom_range(3))
      0: file_text.push_back(CHAR_CR);
      1: file_text.push_back(CHAR_LF);
      2: file_text.push_back(CHAR_NUL);
      default: ;
    endcase
    while (file_text.size() > FILE_BYTES) void'(file_text.pop_back());
  endtask

  task automatic random_config(input int phase_no);
    logic [63:0] nm;
    logic [3:0]  ln;
    logic [6:0]  lm;
    for (int i = 0; i < 8; i++) nm[63 - 8 * i -: 8] = 8'($urandom_range(8'h61, 8'h7a));
    case ($urandom_range(9))
      0: nm = '0;
      1: nm = '1;
      2: nm = {$urandom, $urandom};
      default: ;
    endcase
    if (phase_no == 0) nm = '1;
    case ($urandom_range(9))
      0: ln = 4'd0;
      1: ln = 4'($urandom_range(9, 15));
      default: ln = 4'($urandom_range(1, 8));
    endcase
    case ($urandom_range(9))
      0: lm = 7'd0;
      1: lm = 7'($urandom_range(65, 127));
      2, 3, 4: lm = 7'($urandom_range(1, 64));
      default: lm = 7'd64;
    endcase
    set_config(nm, ln, lm);
  endtask

  initial begin : stimulus
    int phase_no;
    int cut;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.start_req   <= 1'b0;
    in_ch.cipher_byte <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_KEY_NAME;
    cfg_ch.data       <= 64'd0;
    restart_search();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].wr) set_config(dir_rows[r].name, dir_rows[r].nlen, dir_rows[r].lim);
      load_row(dir_rows[r]);
      send_file(dir_rows[r].start);
      drain();
      if (dir_rows[r].chk && (last_code !== dir_rows[r].code || last_len !== dir_rows[r].len))
      begin
        mismatches++;
        $display("%0t: case %0d status expected %0d/%0d, got %0d/%0d", $time, r,
                 dir_rows[r].code, dir_rows[r].len, last_code, last_len);
      end
    end

    items_sent    = 0;
    statuses_seen = 0;
    phase_no      = 0;
    while (items_sent < 250 || statuses_seen < 30) begin
      random_config(phase_no);
      if (phase_no == 1) hold_rx = 1'b1;
      quiet = (phase_no == 3 || phase_no == 4);
      repeat ($urandom_range(3, 8)) begin
        make_random_file();
        if ($urandom_range(9) == 0) begin
          cut = $urandom_range(1, file_text.size());
          while (file_text.size() > cut) void'(file_text.pop_back());
        end
        send_file($urandom_range(9) != 0);
      end
      close_search();
      quiet = 1'b0;
      drain();
      phase_no++;
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && lookup_results_due.size() == 0)
      $display("scrambled_key_value_lookup_top_tb: clean");
    else
      $display("scrambled_key_value_lookup_top_tb: errors");
    $finish;
  end

endmodule
